/* hw/rtl/crcse_pkg.sv */
// Shared types, constants and a CRC-32C helper function for the stream engine.
package crcse_pkg;

    localparam int unsigned BYTES_PER_ITEM_DEF = 8;
    localparam int unsigned QUEUE_DEPTH_DEF    = 2;
    localparam int unsigned CRC_W              = 32;
    localparam int unsigned COUNT_W            = 4;
    localparam logic [CRC_W-1:0] CRC_POLY      = 32'h82F6_3B78;
    localparam logic [CRC_W-1:0] CRC_ONES      = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [63:0]        data_word;
        logic [COUNT_W-1:0] byte_count;
        logic               start_message;
    } in_item_t;

    typedef struct packed {
        logic [CRC_W-1:0] running_state;
        logic [CRC_W-1:0] checksum;
    } out_item_t;

    typedef struct packed {
        logic               start_message;
        logic [COUNT_W-1:0] byte_count;
        logic [CRC_W-1:0]   data_part;
    } work_t;

    // State after folding nbytes zero bytes into a state that has only bit bitpos set.
    function automatic logic [CRC_W-1:0] zero_fold_col(int unsigned nbytes,
                                                       int unsigned bitpos);
        logic [CRC_W-1:0] c;
        c = CRC_W'(1) << bitpos;
        for (int unsigned s = 0; s < nbytes * 8; s++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

/* hw/rtl/crc32c_stream_engine_unit.sv */
// Top level of the CRC-32C stream engine with queue-style input and result ports.
//
// Computes the reflected CRC-32C over up to BYTES_PER_ITEM bytes per transfer, lowest
// byte first, and returns the raw running state and the finished checksum for every
// input transfer. A transfer with start_message set begins from the seed register.
// The engine sustains one transfer per clock cycle while nothing stalls. A transfer is
// registered in the work queue, then passes the back stage, which updates the 32-bit
// running state through a constant XOR network, and is registered in the result queue
// before it shows on the result ports. The front stage folds the data bytes independently
// of the state. Queues of QUEUE_DEPTH entries sit between the input, the back stage and
// the result ports, so each side can stall on its own.
module crc32c_stream_engine_unit #(
    parameter int unsigned BYTES_PER_ITEM = crcse_pkg::BYTES_PER_ITEM_DEF,
    parameter int unsigned QUEUE_DEPTH    = crcse_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 seed_wr_en,
    input  logic [31:0]          seed_wr_data,
    input  logic                 push,
    output logic                 full,
    input  crcse_pkg::in_item_t  item,
    output logic                 empty,
    input  logic                 pop,
    output crcse_pkg::out_item_t result
);
    import crcse_pkg::*;

    work_t     work_in;
    work_t     work_head;
    logic      work_empty;
    logic      work_pop;
    out_item_t res;
    logic      res_push;
    logic      res_full;

    crcse_front #(
        .BYTES_PER_ITEM(BYTES_PER_ITEM)
    ) u_front (
        .item(item),
        .work(work_in)
    );

    crcse_queue #(
        .item_t(work_t),
        .DEPTH (QUEUE_DEPTH)
    ) u_work_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_item(work_in),
        .full   (full),
        .pop    (work_pop),
        .rd_item(work_head),
        .empty  (work_empty)
    );

    crcse_back #(
        .BYTES_PER_ITEM(BYTES_PER_ITEM)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .seed_wr_en  (seed_wr_en),
        .seed_wr_data(seed_wr_data),
        .work        (work_head),
        .work_empty  (work_empty),
        .work_pop    (work_pop),
        .res         (res),
        .res_push    (res_push),
        .res_full    (res_full)
    );

    crcse_queue #(
        .item_t(out_item_t),
        .DEPTH (QUEUE_DEPTH)
    ) u_result_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (res_push),
        .wr_item(res),
        .full   (res_full),
        .pop    (pop),
        .rd_item(result),
        .empty  (empty)
    );

endmodule

/* hw/rtl/crcse_queue.sv */
// Small first-in first-out queue with registered storage and occupancy count.
module crcse_queue #(
    parameter type         item_t = logic,
    parameter int unsigned DEPTH  = 2
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t wr_item,
    output logic  full,
    input  logic  pop,
    output item_t rd_item,
    output logic  empty
);
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    item_t             mem [0:DEPTH-1];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_item = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

/* hw/rtl/crcse_front.sv */
// Front end: saturates the byte count and folds the data bytes into a state-free term.
module crcse_front #(
    parameter int unsigned BYTES_PER_ITEM = 8
) (
    input  crcse_pkg::in_item_t item,
    output crcse_pkg::work_t    work
);
    import crcse_pkg::*;

    localparam int unsigned N_W = $clog2(BYTES_PER_ITEM + 1);

    logic [CRC_W-1:0] bytecol [0:BYTES_PER_ITEM][0:7];
    logic [N_W-1:0]   n_sat;
    logic [N_W-1:0]   span;
    logic [CRC_W-1:0] dpart;

    for (genvar m = 0; m <= BYTES_PER_ITEM; m++)
    begin : g_len
        for (genvar k = 0; k < 8; k++)
        begin : g_bit
            assign bytecol[m][k] = zero_fold_col(m, k);
        end
    end

    always_comb
    begin
        if (item.byte_count > COUNT_W'(BYTES_PER_ITEM))
        begin
            n_sat = N_W'(BYTES_PER_ITEM);
        end
        else
        begin
            n_sat = item.byte_count[N_W-1:0];
        end
    end

    // Byte i is folded through the remaining n - i byte steps.
    always_comb
    begin
        dpart = '0;
        span  = '0;
        for (int unsigned i = 0; i < BYTES_PER_ITEM; i++)
        begin
            span = n_sat - N_W'(i);
            if (n_sat > N_W'(i))
            begin
                for (int unsigned k = 0; k < 8; k++)
                begin
                    if (item.data_word[8 * i + k])
                    begin
                        dpart = dpart ^ bytecol[span][k];
                    end
                end
            end
        end
    end

    assign work.start_message = item.start_message;
    assign work.byte_count    = COUNT_W'(n_sat);
    assign work.data_part     = dpart;

endmodule

/* hw/rtl/crcse_back.sv */
// Back end: holds seed and running state and applies each queued word to the state.
module crcse_back #(
    parameter int unsigned BYTES_PER_ITEM = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 seed_wr_en,
    input  logic [31:0]          seed_wr_data,
    input  crcse_pkg::work_t     work,
    input  logic                 work_empty,
    output logic                 work_pop,
    output crcse_pkg::out_item_t res,
    output logic                 res_push,
    input  logic                 res_full
);
    import crcse_pkg::*;

    localparam int unsigned N_W = $clog2(BYTES_PER_ITEM + 1);

    logic [CRC_W-1:0] statecol [0:BYTES_PER_ITEM][0:CRC_W-1];
    logic [CRC_W-1:0] seed_reg;
    logic [CRC_W-1:0] state_reg;
    logic [CRC_W-1:0] state_next;
    logic [CRC_W-1:0] base;
    logic [N_W-1:0]   n;
    logic             take;

    for (genvar m = 0; m <= BYTES_PER_ITEM; m++)
    begin : g_len
        for (genvar k = 0; k < CRC_W; k++)
        begin : g_bit
            assign statecol[m][k] = zero_fold_col(m, k);
        end
    end

    assign take = !work_empty && !res_full;
    assign n    = work.byte_count[N_W-1:0];
    assign base = work.start_message ? seed_reg : state_reg;

    always_comb
    begin
        state_next = work.data_part;
        for (int unsigned k = 0; k < CRC_W; k++)
        begin
            if (base[k])
            begin
                state_next = state_next ^ statecol[n][k];
            end
        end
    end

    assign work_pop          = take;
    assign res_push          = take;
    assign res.running_state = state_next;
    assign res.checksum      = state_next ^ CRC_ONES;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg  <= CRC_ONES;
            state_reg <= CRC_ONES;
        end
        else
        begin
            if (seed_wr_en)
            begin
                seed_reg <= seed_wr_data;
            end
            if (take)
            begin
                state_reg <= state_next;
            end
        end
    end

endmodule

/* hw/rtl/crcse_checker.sv */
// Port-level checker for the CRC-32C stream engine and its bind to the top level.
module crcse_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 seed_wr_en,
    input logic [31:0]          seed_wr_data,
    input logic                 push,
    input logic                 full,
    input crcse_pkg::in_item_t  item,
    input logic                 empty,
    input logic                 pop,
    input crcse_pkg::out_item_t result
);
    import crcse_pkg::*;

    // The checksum shown is always the complement of the running state.
    a_checksum_matches: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.checksum == (result.running_state ^ CRC_ONES)))
        else $error("checksum is not the complement of the running state");

    // A result that is not taken stays on the ports unchanged.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting result changed or vanished before its transfer");

    // The input side can only back up once results are waiting.
    a_full_implies_results: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !empty)
        else $error("input side full while no result is waiting");

endmodule

bind crc32c_stream_engine_unit crcse_checker u_checker (.*);
